>>> hw/rtl/interval_set_insert_merge_assert.svh
// Assertion helpers for the interval set block.
`ifndef INTERVAL_SET_INSERT_MERGE_ASSERT_SVH
`define INTERVAL_SET_INSERT_MERGE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define ISIM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is asserted.
`define ISIM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/isim_pkg.sv
package isim_pkg;

	localparam int unsigned MaxIntervalsDefault = 64;

	// Result status codes
	localparam logic [1:0] StatusOk       = 2'd0;
	localparam logic [1:0] StatusFull     = 2'd1;
	localparam logic [1:0] StatusZeroLen  = 2'd2;
	localparam logic [1:0] StatusWrap     = 2'd3;

	// Operation broadcast to every cell
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_MERGE,
		OP_SHIFT
	} op_t;

	// One interval: [start, stop)
	typedef struct packed {
		logic [31:0] start;
		logic [32:0] stop;
	} entry_t;

	// Per-cell classification against the request range
	typedef struct packed {
		logic below;   // ends strictly before the range start
		logic touch;   // overlaps or abuts the range
		logic lo_hit;  // touched and starts before the range
		logic hi_hit;  // touched and ends after the range
	} cell_flags_t;

endpackage

>>> hw/rtl/isim_cell.sv
module isim_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  isim_pkg::op_t         op,
	input  logic                  valid,
	input  isim_pkg::entry_t      req,
	input  isim_pkg::entry_t      merged,
	input  isim_pkg::entry_t      left_data,
	input  logic                  left_below,
	input  isim_pkg::entry_t      right_data,
	input  logic                  right_kill,
	input  logic                  seen_in,
	output isim_pkg::entry_t      data,
	output isim_pkg::cell_flags_t flags,
	output logic                  kill,
	output logic                  seen_out
);
	import isim_pkg::*;

	entry_t data_q;
	logic   kill_q;
	logic   below;
	logic   above;
	logic   touch;
	logic   seen;

	// Classify the held interval against the request
	always_comb begin
		below = valid && (data_q.stop < {1'b0, req.start});
		above = valid && ({1'b0, data_q.start} > req.stop);
		touch = valid && !below && !above;
		flags.below  = below;
		flags.touch  = touch;
		flags.lo_hit = touch && (data_q.start < req.start);
		flags.hi_hit = touch && (data_q.stop > req.stop);
	end

	// Prefix of pending kills along the chain
	assign seen     = seen_in | kill_q;
	assign seen_out = seen;
	assign data     = data_q;
	assign kill     = kill_q;

	// Payload: insert shifts right, merge writes the merged interval, compaction shifts left
	always_ff @(posedge clk) begin
		case (op)
			OP_INSERT: begin
				if (!below) begin
					data_q <= left_below ? req : left_data;
				end
			end
			OP_MERGE: begin
				if (touch && left_below) begin
					data_q <= merged;
				end
			end
			OP_SHIFT: begin
				if (seen) begin
					data_q <= right_data;
				end
			end
			default: begin
			end
		endcase
	end

	// Kill marks travel with the payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kill_q <= 1'b0;
		end else begin
			case (op)
				OP_INSERT: if (!below) kill_q <= 1'b0;
				OP_MERGE:  if (touch) kill_q <= !left_below;
				OP_SHIFT:  if (seen) kill_q <= right_kill;
				default: begin
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/interval_set_insert_merge.sv
// Interval set with coalescing insert.
// Request channel: range_start/range_len are taken at a rising edge where
// start is high and busy is low. busy stays high until the result is out.
// Result channel: done pulses for one cycle with status, cover_start,
// cover_end and entry_count; the receiver must take it in that cycle.
// Storage is a row of MAX_INTERVALS cells, one interval each, kept sorted.
// Sequence from accept to done: ST_CLASS finishes the request when the
// range inserts or is rejected; on a merge it writes the merged interval
// into the first touched cell and marks the other swallowed entries, then
// ST_SHIFT compacts the row left by one cell per step until none remain.
// A new request is taken only once the previous one is done.
// Reset empties the table (count to zero) at once; no clearing pass.
// Entries at or above the count are never read.
module interval_set_insert_merge #(
	parameter int unsigned MAX_INTERVALS = isim_pkg::MaxIntervalsDefault
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [31:0]                           range_start,
	input  logic [7:0]                            range_len,
	output logic                                  done,
	output logic [1:0]                            status,
	output logic [31:0]                           cover_start,
	output logic [32:0]                           cover_end,
	output logic [$clog2(MAX_INTERVALS+1)-1:0]    entry_count
);
	import isim_pkg::*;
	`include "interval_set_insert_merge_assert.svh"

	localparam int unsigned CW = $clog2(MAX_INTERVALS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CLASS,
		ST_SHIFT
	} state_t;

	state_t         state_q;
	logic [CW-1:0]  count_q;
	entry_t         req_q;
	logic           zero_q;
	logic           done_q;
	logic [1:0]     status_q;
	entry_t         res_q;
	logic [CW-1:0]  count_out_q;

	op_t            op;
	entry_t         merged;
	entry_t         cell_data [MAX_INTERVALS];
	cell_flags_t    cell_flags[MAX_INTERVALS];
	logic           cell_kill [MAX_INTERVALS];
	logic           cell_seen [MAX_INTERVALS];
	logic           any_touch;
	logic           lo_any;
	logic           hi_any;
	logic [31:0]    lo_val;
	logic [32:0]    hi_val;
	logic           wrap;
	logic           full;

	// Request checks
	assign wrap = req_q.stop[32] && (req_q.stop[31:0] != 32'd0);
	assign full = (count_q == CW'(MAX_INTERVALS));

	// Gather the merged interval: at most one cell hits on each side
	always_comb begin
		any_touch = 1'b0;
		lo_any    = 1'b0;
		hi_any    = 1'b0;
		lo_val    = '0;
		hi_val    = '0;
		for (int i = 0; i < MAX_INTERVALS; i++) begin
			any_touch = any_touch | cell_flags[i].touch;
			lo_any    = lo_any | cell_flags[i].lo_hit;
			hi_any    = hi_any | cell_flags[i].hi_hit;
			lo_val    = lo_val | (cell_data[i].start & {32{cell_flags[i].lo_hit}});
			hi_val    = hi_val | (cell_data[i].stop & {33{cell_flags[i].hi_hit}});
		end
		merged.start = lo_any ? lo_val : req_q.start;
		merged.stop  = hi_any ? hi_val : req_q.stop;
	end

	// Operation for the row
	always_comb begin
		op = OP_HOLD;
		unique case (state_q)
			ST_CLASS: begin
				if (!zero_q && !wrap) begin
					if (any_touch) op = OP_MERGE;
					else if (!full) op = OP_INSERT;
				end
			end
			ST_SHIFT: op = OP_SHIFT;
			default: op = OP_HOLD;
		endcase
	end

	// Row of cells
	for (genvar g = 0; g < MAX_INTERVALS; g++) begin : g_cell
		entry_t lft;
		entry_t rgt;
		logic   lbelow;
		logic   rkill;
		logic   sin;
		if (g == 0) begin : g_first
			assign lft    = '0;
			assign lbelow = 1'b1;
			assign sin    = 1'b0;
		end else begin : g_mid
			assign lft    = cell_data[g-1];
			assign lbelow = cell_flags[g-1].below;
			assign sin    = cell_seen[g-1];
		end
		if (g == MAX_INTERVALS - 1) begin : g_last
			assign rgt   = '0;
			assign rkill = 1'b0;
		end else begin : g_inner
			assign rgt   = cell_data[g+1];
			assign rkill = cell_kill[g+1];
		end
		isim_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (op),
			.valid      (CW'(g) < count_q),
			.req        (req_q),
			.merged     (merged),
			.left_data  (lft),
			.left_below (lbelow),
			.right_data (rgt),
			.right_kill (rkill),
			.seen_in    (sin),
			.data       (cell_data[g]),
			.flags      (cell_flags[g]),
			.kill       (cell_kill[g]),
			.seen_out   (cell_seen[g])
		);
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			req_q.start <= range_start;
			req_q.stop  <= {1'b0, range_start} + {25'd0, range_len};
			zero_q      <= (range_len == 8'd0);
		end
	end

	// Control and registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			done_q      <= 1'b0;
			status_q    <= StatusOk;
			res_q       <= '0;
			count_out_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_CLASS;
				end
				ST_CLASS: begin
					count_out_q <= count_q;
					res_q       <= '0;
					if (zero_q) begin
						status_q <= StatusZeroLen;
						done_q   <= 1'b1;
						state_q  <= ST_IDLE;
					end else if (wrap) begin
						status_q <= StatusWrap;
						done_q   <= 1'b1;
						state_q  <= ST_IDLE;
					end else if (any_touch) begin
						status_q <= StatusOk;
						res_q    <= merged;
						state_q  <= ST_SHIFT;
					end else if (full) begin
						status_q <= StatusFull;
						done_q   <= 1'b1;
						state_q  <= ST_IDLE;
					end else begin
						status_q    <= StatusOk;
						res_q       <= req_q;
						count_q     <= count_q + CW'(1);
						count_out_q <= count_q + CW'(1);
						done_q      <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_SHIFT: begin
					if (cell_seen[MAX_INTERVALS-1]) begin
						count_q <= count_q - CW'(1);
					end else begin
						count_out_q <= count_q;
						done_q      <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign cover_start = res_q.start;
	assign cover_end   = res_q.stop;
	assign entry_count = count_out_q;

	`ISIM_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(MAX_INTERVALS), "count past capacity")
	`ISIM_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted request not busy")
	`ISIM_ASSERT_NOW(a_done_idle, done, !busy, "result while busy")
	`ISIM_ASSERT_NOW(a_ok_nonempty, done && status == StatusOk,
		(cover_end > {1'b0, cover_start}) && (entry_count != '0), "empty cover on ok")

endmodule
